// File: hw/rtl/spa_pkg.sv
// Shared constants and control types for the slot pool allocator.
`default_nettype none

package spa_pkg;

  localparam int Slots   = 64;
  localparam int SlotW   = $clog2(Slots);
  localparam int CapW    = 7;
  localparam int BytesW  = 13;
  localparam int OffW    = 18;
  localparam int CntW    = 7;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = SlotW + BytesW;

  localparam logic [BytesW-1:0] MaxElemBytes = BytesW'(4096);

  // input word modes; the fourth code does nothing
  localparam logic [1:0] ModeAlloc  = 2'd0;
  localparam logic [1:0] ModeLookup = 2'd1;
  localparam logic [1:0] ModeFree   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPoolCapacity = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgElementBytes = CfgIdxW'(1);

  typedef struct packed {
    logic load;   // latch an accepted input word
    logic find;   // run the slot searches
    logic apply;  // update the pool and load the output register
  } spa_cmd_t;

  typedef struct packed {
    logic out_blocked;  // output register holds a word that is stalled
  } spa_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/spa_ctrl.sv
// Sequencer for the slot pool allocator: accept, search, apply.
`default_nettype none

module spa_ctrl
  import spa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire spa_status_t status_i,
  output spa_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFind,
    StApply
  } state_e;

  state_e state_q, state_d;
  logic   can_load;
  logic   accept;

  assign can_load   = !status_i.out_blocked;
  // a new word may enter while the previous one lands in the output register
  assign in_stall_o = !((state_q == StIdle) || ((state_q == StApply) && can_load));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StFind;
      end
      StFind: begin
        state_d = StApply;
      end
      StApply: begin
        if (can_load) state_d = accept ? StFind : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.find  = (state_q == StFind);
    cmd_o.apply = (state_q == StApply) && can_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spa_datapath.sv
// Occupancy flags, slot searches, counters and output register.
`default_nettype none

module spa_datapath
  import spa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spa_cmd_t           cmd_i,
  output spa_status_t             status_o,
  input  wire logic [1:0]         in_mode_i,
  input  wire logic [SlotW-1:0]   in_slot_index_i,
  input  wire logic               cfg_write_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [BytesW-1:0]  cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    out_ok_o,
  output logic [SlotW-1:0]        out_result_slot_o,
  output logic [OffW-1:0]         out_byte_offset_o,
  output logic [CntW-1:0]         out_taken_count_o,
  output logic [SlotW-1:0]        out_highest_used_o
);

  logic [CapW-1:0]   cap_raw_q;
  logic [BytesW-1:0] bytes_raw_q;
  logic [CapW-1:0]   cap_eff;
  logic [BytesW-1:0] bytes_eff;

  logic [1:0]        mode_q;
  logic [SlotW-1:0]  idx_q;

  logic [Slots-1:0]  taken_q, taken_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SlotW-1:0]  high_q, high_d;

  // search results
  logic [Slots-1:0]  cap_mask;
  logic [Slots-1:0]  free_mask;
  logic [Slots-1:0]  taken_wo;
  logic [SlotW-1:0]  low_free;
  logic [SlotW-1:0]  high_wo;
  logic              hit;
  logic [SlotW-1:0]  fs_q;
  logic              fany_q;
  logic              hit_q;
  logic [SlotW-1:0]  hiwo_q;

  logic              ok_d;
  logic [SlotW-1:0]  slot_d;
  logic [ProdW-1:0]  prod;

  logic              out_valid_q;
  logic              ok_q;
  logic [SlotW-1:0]  slot_q;
  logic [OffW-1:0]   off_q;
  logic [CntW-1:0]   cnt_out_q;
  logic [SlotW-1:0]  high_out_q;

  always_comb begin
    if (cap_raw_q == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_raw_q > CapW'(Slots)) begin
      cap_eff = CapW'(Slots);
    end else begin
      cap_eff = cap_raw_q;
    end
    if (bytes_raw_q == '0) begin
      bytes_eff = BytesW'(1);
    end else if (bytes_raw_q > MaxElemBytes) begin
      bytes_eff = MaxElemBytes;
    end else begin
      bytes_eff = bytes_raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q   <= CapW'(Slots);
      bytes_raw_q <= BytesW'(1);
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CfgPoolCapacity: cap_raw_q   <= cfg_data_i[CapW-1:0];
        CfgElementBytes: bytes_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      idx_q  <= in_slot_index_i;
    end
  end

  // priority searches over the flag vector
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      cap_mask[i] = (CapW'(i) < cap_eff);
    end
    free_mask = ~taken_q & cap_mask;
    taken_wo  = taken_q;
    taken_wo[idx_q] = 1'b0;
    low_free = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (free_mask[i]) low_free = SlotW'(i);
    end
    high_wo = '0;
    for (int i = 0; i < Slots; i++) begin
      if (taken_wo[i]) high_wo = SlotW'(i);
    end
    hit = taken_q[idx_q] && ({1'b0, idx_q} < cap_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      fs_q   <= low_free;
      fany_q <= |free_mask;
      hit_q  <= hit;
      hiwo_q <= high_wo;
    end
  end

  always_comb begin
    taken_d = taken_q;
    count_d = count_q;
    high_d  = high_q;
    ok_d    = 1'b0;
    slot_d  = idx_q;
    case (mode_q)
      ModeAlloc: begin
        slot_d = '0;
        if (fany_q) begin
          taken_d[fs_q] = 1'b1;
          count_d = count_q + CntW'(1);
          if (fs_q > high_q) high_d = fs_q;
          ok_d   = 1'b1;
          slot_d = fs_q;
        end
      end
      ModeLookup: begin
        ok_d = hit_q;
      end
      ModeFree: begin
        if (hit_q) begin
          taken_d[idx_q] = 1'b0;
          if (idx_q == high_q) high_d = hiwo_q;
          if (count_q != '0) count_d = count_q - CntW'(1);
          ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign prod = slot_d * bytes_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= '0;
      count_q     <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        taken_q     <= taken_d;
        count_q     <= count_d;
        high_q      <= high_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      ok_q       <= ok_d;
      slot_q     <= slot_d;
      off_q      <= ok_d ? prod[OffW-1:0] : '0;
      cnt_out_q  <= count_d;
      high_out_q <= high_d;
    end
  end

  assign status_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign out_ok_o           = ok_q;
  assign out_result_slot_o  = slot_q;
  assign out_byte_offset_o  = off_q;
  assign out_taken_count_o  = cnt_out_q;
  assign out_highest_used_o = high_out_q;

endmodule

`default_nettype wire

// File: hw/rtl/slot_pool_allocator.sv
// Top level of the first-fit slot pool allocator.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | mode, slot_index
//   out     | out | out_valid/out_stall| ok, result_slot, byte_offset, taken_count,
//           |     |                    | highest_used
//   cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each word passes a search step, the lowest-free and highest-used priority
// searches over the 64 flag registers, then an update step that updates the flags and
// multiplies the offset into the output register. The next word is taken in the update step.
// Reset clears all flags and counters at once; capacity 64 and element size 1.
// A stalled output word holds the update cycle until it leaves.
`default_nettype none

module slot_pool_allocator
  import spa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         in_mode_i,
  input  wire logic [SlotW-1:0]   in_slot_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    out_ok_o,
  output logic [SlotW-1:0]        out_result_slot_o,
  output logic [OffW-1:0]         out_byte_offset_o,
  output logic [CntW-1:0]         out_taken_count_o,
  output logic [SlotW-1:0]        out_highest_used_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [BytesW-1:0]  cfg_data_i
);

  spa_cmd_t    cmd;
  spa_status_t status;

  assign cfg_ready_o = 1'b1;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spa_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_mode_i          (in_mode_i),
    .in_slot_index_i    (in_slot_index_i),
    .cfg_write_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_ok_o           (out_ok_o),
    .out_result_slot_o  (out_result_slot_o),
    .out_byte_offset_o  (out_byte_offset_o),
    .out_taken_count_o  (out_taken_count_o),
    .out_highest_used_o (out_highest_used_o)
  );

  // a word spends its search cycle behind a raised stall
  a_search_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during search cycle");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ok_o |-> out_byte_offset_o == '0)
    else $error("refused word carries an offset");

  a_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_taken_count_o == '0 |-> out_highest_used_o == '0)
    else $error("highest used slot set on empty pool");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_taken_count_o <= CntW'(Slots))
    else $error("taken count beyond slot count");

endmodule

`default_nettype wire

// File: test/spa_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the slot pool allocator: tracks the pool, predicts and compares each word.
module spa_result_checker
  import spa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [1:0]         in_mode_i,
  input  wire logic [SlotW-1:0]   in_slot_index_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               out_ok_i,
  input  wire logic [SlotW-1:0]   out_result_slot_i,
  input  wire logic [OffW-1:0]    out_byte_offset_i,
  input  wire logic [CntW-1:0]    out_taken_count_i,
  input  wire logic [SlotW-1:0]   out_highest_used_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [BytesW-1:0]  cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot;
    logic [OffW-1:0]  offset;
    logic [CntW-1:0]  count;
    logic [SlotW-1:0] highest;
  } pool_result_t;

  pool_result_t      expected_words[$];

  logic [Slots-1:0]  taken_q;
  logic [SlotW-1:0]  highest_q;
  logic [CntW-1:0]   count_q;
  logic [CapW-1:0]   capacity_q;
  logic [BytesW-1:0] elem_bytes_q;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Applies one word to the tracked pool and returns the word the block should send.
  function automatic pool_result_t predict_result(input logic [1:0] mode,
                                                  input logic [SlotW-1:0] idx);
    pool_result_t r;
    int cap;
    int bytes;
    int s;
    int h;
    int i;
    cap = (capacity_q == 0) ? 1 : (capacity_q > Slots) ? Slots : int'(capacity_q);
    bytes = (elem_bytes_q == 0) ? 1 :
            (elem_bytes_q > MaxElemBytes) ? int'(MaxElemBytes) : int'(elem_bytes_q);
    r.ok = 1'b0;
    r.slot = idx;
    r.offset = '0;
    case (mode)
      ModeAlloc: begin
        r.slot = '0;
        s = cap;
        for (i = cap - 1; i >= 0; i--) begin
          if (!taken_q[i]) s = i;
        end
        if (s < cap) begin
          taken_q[s] = 1'b1;
          if (s > highest_q) highest_q = SlotW'(s);
          count_q++;
          r.ok = 1'b1;
          r.slot = SlotW'(s);
          r.offset = OffW'(s * bytes);
        end
      end
      ModeLookup: begin
        if (idx < cap && taken_q[idx]) begin
          r.ok = 1'b1;
          r.offset = OffW'(int'(idx) * bytes);
        end
      end
      ModeFree: begin
        if (idx < cap && taken_q[idx]) begin
          taken_q[idx] = 1'b0;
          // freeing the top slot: next highest taken one below it, else zero
          if (idx == highest_q) begin
            h = 0;
            for (i = 0; i < idx; i++) begin
              if (taken_q[i]) h = i;
            end
            highest_q = SlotW'(h);
          end
          if (count_q != 0) count_q--;
          r.ok = 1'b1;
          r.offset = OffW'(int'(idx) * bytes);
        end
      end
      default: ;
    endcase
    r.count = count_q;
    r.highest = highest_q;
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    pool_result_t want;
    if (!rst_ni) begin
      taken_q = '0;
      highest_q = '0;
      count_q = '0;
      capacity_q = CapW'(64);
      elem_bytes_q = BytesW'(1);
      expected_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("ok", 32'(out_ok_i), 32'(want.ok));
          check_field("result_slot", 32'(out_result_slot_i), 32'(want.slot));
          check_field("byte_offset", 32'(out_byte_offset_i), 32'(want.offset));
          check_field("taken_count", 32'(out_taken_count_i), 32'(want.count));
          check_field("highest_used", 32'(out_highest_used_i), 32'(want.highest));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPoolCapacity: capacity_q = cfg_data_i[CapW-1:0];
          CfgElementBytes: elem_bytes_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(predict_result(in_mode_i, in_slot_index_i));
      end
    end
    pending_o <= expected_words.size();
  end

endmodule

// File: test/slot_pool_allocator_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the slot pool allocator: stimulus, configuration and verdict.
module slot_pool_allocator_tb;
  import spa_pkg::*;

  localparam logic [1:0] ModeNop = 2'd3;
  localparam int NumPhases     = 12;
  localparam int WordsPerPhase = 80;
  localparam int CycleLimit    = 400000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         in_mode_i = ModeAlloc;
  logic [SlotW-1:0]   in_slot_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               out_ok_o;
  logic [SlotW-1:0]   out_result_slot_o;
  logic [OffW-1:0]    out_byte_offset_o;
  logic [CntW-1:0]    out_taken_count_o;
  logic [SlotW-1:0]   out_highest_used_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgPoolCapacity;
  logic [BytesW-1:0]  cfg_data_i = '0;

  int mismatch_count;
  int pending_words;
  int checked_words;
  int cycle_count;
  int words_sent;
  int settings_used;
  int stall_hold;
  int stall_roll;
  bit quiet;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  slot_pool_allocator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_slot_index_i    (in_slot_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_ok_o           (out_ok_o),
    .out_result_slot_o  (out_result_slot_o),
    .out_byte_offset_o  (out_byte_offset_o),
    .out_taken_count_o  (out_taken_count_o),
    .out_highest_used_o (out_highest_used_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  spa_result_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_slot_index_i    (in_slot_index_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_ok_i           (out_ok_o),
    .out_result_slot_i  (out_result_slot_o),
    .out_byte_offset_i  (out_byte_offset_o),
    .out_taken_count_i  (out_taken_count_o),
    .out_highest_used_i (out_highest_used_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_words),
    .checked_o          (checked_words)
  );

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending_words);
    $display("FAILED: results differ");
    $finish;
  end

  // Output backpressure: short bursts mostly, now and then a long hold.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      out_stall_i <= (stall_roll < 35);
      stall_hold <= (stall_roll < 5 || stall_roll >= 95) ? $urandom_range(8, 40) :
                    $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [1:0] mode, input logic [SlotW-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i <= mode;
    in_slot_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  // Both registers back to back; valid stays high across the pair.
  task automatic set_config(input int cap, input int bytes);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgPoolCapacity;
    cfg_data_i <= BytesW'(cap);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgElementBytes;
    cfg_data_i <= BytesW'(bytes);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int p;
    int cap;
    int bytes;
    int cap_eff;
    int alloc_w;
    int roll;
    int directed;
    logic [1:0] mode;
    logic [SlotW-1:0] idx;

    settings_used = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: capacity 64, one byte per element
    send_word(ModeLookup, 6'd0);
    send_word(ModeFree, 6'd0);
    send_word(ModeNop, 6'd63);
    send_word(ModeAlloc, 6'd0);
    send_word(ModeAlloc, 6'd63);
    send_word(ModeAlloc, 6'd21);
    send_word(ModeLookup, 6'd1);
    send_word(ModeFree, 6'd1);
    send_word(ModeAlloc, 6'd0);
    send_word(ModeFree, 6'd2);    // top slot freed, rescan down
    send_word(ModeLookup, 6'd63);
    send_word(ModeFree, 6'd63);
    repeat (4) send_word(ModeAlloc, 6'd42);

    // zero capacity reads as one; slots above it stay taken but out of reach
    wait_drained();
    set_config(0, 4096);
    send_word(ModeAlloc, 6'd0);
    send_word(ModeLookup, 6'd5);
    send_word(ModeFree, 6'd5);
    send_word(ModeLookup, 6'd0);

    // out-of-range register values clamp to the limits
    wait_drained();
    set_config(127, 8191);
    send_word(ModeLookup, 6'd5);
    send_word(ModeFree, 6'd5);
    directed = words_sent;

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin cap = 64; bytes = 4096; end
        1: begin cap = 1; bytes = 1; end
        2: begin cap = 0; bytes = 0; end
        3: begin cap = 127; bytes = 8191; end
        4: begin cap = 65; bytes = 4095; end
        5: begin cap = 2; bytes = 4096; end
        6: begin cap = 64; bytes = 1; end
        default: begin
          cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
          bytes = $urandom_range(0, 8191);
        end
      endcase
      wait_drained();
      set_config(cap, bytes);
      cap_eff = (cap == 0) ? 1 : (cap > Slots) ? Slots : cap;
      alloc_w = (p == 0) ? 85 : $urandom_range(30, 75);
      quiet = (p % 4 == 3);
      repeat (WordsPerPhase) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_w) mode = ModeAlloc;
        else if (roll < alloc_w + (100 - alloc_w) * 3 / 5) mode = ModeFree;
        else if (roll < 97) mode = ModeLookup;
        else mode = ModeNop;
        // mostly aim inside the live pool so frees and lookups find taken slots
        idx = ($urandom_range(0, 99) < 85) ? SlotW'($urandom_range(0, cap_eff - 1)) :
              SlotW'($urandom_range(0, Slots - 1));
        send_word(mode, idx);
      end
    end

    quiet = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("covered %0d words (%0d directed) over %0d capacity/element-size settings",
             words_sent, directed, settings_used);
    $display("%0d result words checked, %0d mismatches", checked_words, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
